/* sv/disk_header_pattern_finder_assert.svh */
// Assertion macros for the disk header pattern finder checker.
`ifndef DISK_HEADER_PATTERN_FINDER_ASSERT_SVH
`define DISK_HEADER_PATTERN_FINDER_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define DHPF_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that is also checked around reset.
`define DHPF_ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

/* sv/dhpf_pkg.sv */
// Types and constants of the disk header pattern finder.
`default_nettype none

package dhpf_pkg;

   // Scan phases; the two unused codes behave as the search phase.
   typedef enum logic [2:0] {
      PH_SEARCH = 3'd0,
      PH_MATCH  = 3'd1,
      PH_SKIP   = 3'd2,
      PH_GAP    = 3'd3,
      PH_TYPE   = 3'd4,
      PH_COUNT  = 3'd5
   } phase_type;

   // One result transaction.
   typedef struct packed {
      logic        found;
      logic [15:0] position;
      logic [7:0]  disk_count;
   } result_type;

   // Header pattern, padded with zero bytes for longer pattern lengths.
   localparam logic [7:0] HDR_PATTERN [32] = '{
      8'h80, 8'h03, 8'h07, 8'h10, 8'h44, 8'h49, 8'h53, 8'h4B,
      8'h4C, 8'h49, 8'h53, 8'h54, 8'h00, 8'h80, 8'h00, 8'h20,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   localparam logic [7:0]  GAP_BYTE         = 8'h00;
   localparam logic [7:0]  BLOCK_LEAD_BYTE  = 8'h80;
   localparam logic [7:0]  BLOCK_TYPE_LIST  = 8'h04;
   localparam logic [15:0] SCAN_LIMIT_RESET = 16'd65500;
   localparam logic [15:0] POSITION_MAX     = 16'hFFFF;

endpackage

`default_nettype wire

/* sv/disk_header_pattern_finder.sv */
// Each result is registered in a result queue that drives the rsp_ port.
// One byte per cycle while req_stall is low; the scan state updates in a single pass per byte.
// A two-entry result queue stalls the input only when both entries hold results.
// Synchronous active-high reset clears the scan state, empties the result queue
// and sets the scan limit to 65500.
`default_nettype none

module disk_header_pattern_finder
   import dhpf_pkg::*;
#(
   parameter int PATTERN_LEN      = 17,
   parameter int SKIP_AFTER_MATCH = 3
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_restart,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic        rsp_found,
   output      logic [15:0] rsp_position,
   output      logic [7:0]  rsp_disk_count
);

   localparam logic [5:0] PAT_LEN   = 6'(PATTERN_LEN);
   localparam logic [1:0] SKIP_INIT = 2'(SKIP_AFTER_MATCH);

   // Scan state and configuration.
   phase_type   phase_ff, phase_in;
   logic [4:0]  match_idx_ff, match_idx_in;
   logic [1:0]  skip_left_ff, skip_left_in;
   logic [15:0] byte_pos_ff, byte_pos_in;
   logic        finished_ff, finished_in;
   logic [15:0] scan_limit_ff;

   // Result queue: head drives the port, skid catches a result while head is stalled.
   logic        head_valid_ff;
   result_type  head_ff;
   logic        skid_valid_ff;
   result_type  skid_ff;

   // State seen by the current byte after an optional restart.
   phase_type   cur_phase;
   logic [4:0]  cur_idx;
   logic [1:0]  cur_skip;
   logic [15:0] cur_pos;
   logic        cur_fin;
   logic [15:0] pos_bump;
   logic [5:0]  idx_sum;
   logic [1:0]  skip_dec;
   logic        res_valid;
   result_type  res_data;

   logic accept;
   logic push;
   logic pop;

   assign accept = req_valid && !req_stall;
   assign push   = accept && res_valid;
   assign pop    = head_valid_ff && !rsp_stall;

   // Next scan state for the byte on the request port.
   always_comb begin
      cur_phase = phase_ff;
      cur_idx   = match_idx_ff;
      cur_skip  = skip_left_ff;
      cur_pos   = byte_pos_ff;
      cur_fin   = finished_ff;
      if (req_restart) begin
         cur_phase = PH_SEARCH;
         cur_idx   = 5'd0;
         cur_skip  = 2'd0;
         cur_pos   = 16'd0;
         cur_fin   = 1'b0;
      end

      pos_bump = (cur_pos == POSITION_MAX) ? cur_pos : cur_pos + 16'd1;
      idx_sum  = {1'b0, cur_idx} + 6'd1;
      skip_dec = (cur_skip != 2'd0) ? cur_skip - 2'd1 : 2'd0;

      phase_in     = cur_phase;
      match_idx_in = cur_idx;
      skip_left_in = cur_skip;
      byte_pos_in  = cur_pos;
      finished_in  = cur_fin;
      res_valid    = 1'b0;
      res_data     = '{found: 1'b0, position: cur_pos, disk_count: 8'd0};

      if (!cur_fin) begin
         unique case (cur_phase)
            PH_MATCH: begin
               byte_pos_in = pos_bump;
               if (req_data_byte == HDR_PATTERN[cur_idx]) begin
                  if (idx_sum >= PAT_LEN) begin
                     match_idx_in = 5'd0;
                     skip_left_in = SKIP_INIT;
                     phase_in     = (SKIP_INIT != 2'd0) ? PH_SKIP : PH_GAP;
                  end else begin
                     match_idx_in = idx_sum[4:0];
                  end
               end else begin
                  match_idx_in = 5'd0;
                  phase_in     = PH_SEARCH;
               end
            end
            PH_SKIP: begin
               byte_pos_in  = pos_bump;
               skip_left_in = skip_dec;
               phase_in     = (skip_dec == 2'd0) ? PH_GAP : PH_SKIP;
            end
            PH_GAP: begin
               byte_pos_in = pos_bump;
               priority if (req_data_byte == GAP_BYTE && pos_bump < scan_limit_ff) begin
                  phase_in = PH_GAP;
               end else if (req_data_byte == BLOCK_LEAD_BYTE) begin
                  phase_in = PH_TYPE;
               end else begin
                  phase_in = PH_SEARCH;
               end
            end
            PH_TYPE: begin
               byte_pos_in = pos_bump;
               phase_in    = (req_data_byte == BLOCK_TYPE_LIST) ? PH_COUNT : PH_SEARCH;
            end
            PH_COUNT: begin
               // The count byte itself does not advance the position.
               res_valid   = 1'b1;
               res_data    = '{found: 1'b1, position: cur_pos, disk_count: req_data_byte};
               finished_in = 1'b1;
            end
            default: begin
               byte_pos_in = pos_bump;
               if (req_data_byte == HDR_PATTERN[0]) begin
                  match_idx_in = 5'd1;
                  phase_in     = PH_MATCH;
               end else begin
                  phase_in = PH_SEARCH;
               end
            end
         endcase

         // A search that ends up back at the start at or past the limit gives up.
         if (cur_phase != PH_COUNT && phase_in == PH_SEARCH &&
             byte_pos_in >= scan_limit_ff) begin
            res_valid   = 1'b1;
            res_data    = '{found: 1'b0, position: byte_pos_in, disk_count: 8'd0};
            finished_in = 1'b1;
         end
      end
   end

   // Scan state, configuration and queue control.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SEARCH;
         match_idx_ff  <= 5'd0;
         skip_left_ff  <= 2'd0;
         byte_pos_ff   <= 16'd0;
         finished_ff   <= 1'b0;
         scan_limit_ff <= SCAN_LIMIT_RESET;
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            scan_limit_ff <= csr_wr_data;
         end
         if (accept) begin
            phase_ff     <= phase_in;
            match_idx_ff <= match_idx_in;
            skip_left_ff <= skip_left_in;
            byte_pos_ff  <= byte_pos_in;
            finished_ff  <= finished_in;
         end
         if (pop) begin
            head_valid_ff <= skid_valid_ff || push;
            skid_valid_ff <= 1'b0;
         end else if (!head_valid_ff) begin
            head_valid_ff <= push;
         end else if (push) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   // Result queue payload.
   always_ff @(posedge clock) begin
      if (pop) begin
         if (skid_valid_ff) begin
            head_ff <= skid_ff;
         end else if (push) begin
            head_ff <= res_data;
         end
      end else if (!head_valid_ff) begin
         if (push) begin
            head_ff <= res_data;
         end
      end else if (push) begin
         skid_ff <= res_data;
      end
   end

   assign req_stall      = skid_valid_ff;
   assign rsp_valid      = head_valid_ff;
   assign rsp_found      = head_ff.found;
   assign rsp_position   = head_ff.position;
   assign rsp_disk_count = head_ff.disk_count;

endmodule

`default_nettype wire

/* sv/dhpf_checker.sv */
// Port-level checker for the disk header pattern finder, bound to the top level.
`default_nettype none

`include "disk_header_pattern_finder_assert.svh"

module dhpf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_found,
   input wire logic [15:0] rsp_position,
   input wire logic [7:0]  rsp_disk_count
);

   // A stalled result transaction stays offered.
   `DHPF_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "rsp_valid dropped while stalled")

   // A stalled result transaction keeps its payload.
   `DHPF_ASSERT_RST(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_found) && $stable(rsp_position) && $stable(rsp_disk_count), "rsp payload changed while stalled")

   // A search that gave up reports a zero disk count.
   `DHPF_ASSERT_RST(a_not_found_count, clock, reset, rsp_valid && !rsp_found |-> rsp_disk_count == 8'd0, "nonzero disk count on not found")

   // The input only stalls when the result queue holds a waiting result.
   `DHPF_ASSERT_RST(a_stall_needs_rsp, clock, reset, req_stall |-> rsp_valid, "input stalled with empty result queue")

   // The result queue comes out of reset empty.
   `DHPF_ASSERT_CLK(a_reset_empty, clock, $past(reset) |-> !rsp_valid && !req_stall, "result queue not empty after reset")

endmodule

bind disk_header_pattern_finder dhpf_checker u_dhpf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_found      (rsp_found),
   .rsp_position   (rsp_position),
   .rsp_disk_count (rsp_disk_count)
);

`default_nettype wire
